// File: rtl/lpd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
package lpd_pkg;

   // Code bytes that open a packet
   localparam logic [7:0] CODE_SHORT_A = 8'hC1;
   localparam logic [7:0] CODE_SHORT_B = 8'hC3;
   localparam logic [7:0] CODE_LONG_A  = 8'hC2;
   localparam logic [7:0] CODE_LONG_B  = 8'hC4;

   // Header sizes in bytes, code byte included
   localparam logic [15:0] HDR_SHORT = 16'd2;
   localparam logic [15:0] HDR_LONG  = 16'd3;

   // Error codes carried with each item
   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_CODE    = 2'd1,
      ERR_LENGTH  = 2'd2
   } err_type;

   // Framing phase
   typedef enum logic [1:0] {
      PH_CODE   = 2'd0,
      PH_LEN    = 2'd1,
      PH_LEN_LO = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   // One marked output item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_packet;
      logic       start_of_packet;
      logic       end_of_packet;
      err_type    error_code;
      logic       long_header;
   } result_type;

endpackage

// File: rtl/lpd_in_stage.sv
// Input register that holds one received byte until the framer takes it.
module lpd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // Accept when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the byte on accept
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// File: rtl/lpd_framer.sv
// Framing state machine: marks each byte and tracks header phase and body count.
module lpd_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            item_byte,
   output lpd_pkg::result_type   result
);

   lpd_pkg::phase_type phase_ff, phase_in;
   logic               is_long_ff, is_long_in;
   logic [7:0]         length_high_ff, length_high_in;
   logic [15:0]        remaining_ff, remaining_in;

   logic        is_short_code;
   logic        is_long_code;
   logic [15:0] total;
   logic [15:0] header;
   logic        too_short;
   logic        exact;
   logic        last_len_byte;
   logic        body_last;

   // Decode the code byte and the finished length
   assign is_short_code = (item_byte == lpd_pkg::CODE_SHORT_A) ||
                          (item_byte == lpd_pkg::CODE_SHORT_B);
   assign is_long_code  = (item_byte == lpd_pkg::CODE_LONG_A) ||
                          (item_byte == lpd_pkg::CODE_LONG_B);
   assign total         = is_long_ff ? {length_high_ff, item_byte} : {8'd0, item_byte};
   assign header        = is_long_ff ? lpd_pkg::HDR_LONG : lpd_pkg::HDR_SHORT;
   assign too_short     = total < header;
   assign exact         = total == header;
   assign last_len_byte = (phase_ff == lpd_pkg::PH_LEN_LO) ||
                          ((phase_ff == lpd_pkg::PH_LEN) && !is_long_ff);
   assign body_last     = remaining_ff <= 16'd1;

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      is_long_in     = is_long_ff;
      length_high_in = length_high_ff;
      remaining_in   = remaining_ff;
      case (phase_ff)
         lpd_pkg::PH_CODE: begin
            if (is_short_code || is_long_code) begin
               is_long_in = is_long_code;
               phase_in   = lpd_pkg::PH_LEN;
            end
         end
         lpd_pkg::PH_LEN, lpd_pkg::PH_LEN_LO: begin
            if (!last_len_byte) begin
               length_high_in = item_byte;
               phase_in       = lpd_pkg::PH_LEN_LO;
            end else if (too_short || exact) begin
               phase_in = lpd_pkg::PH_CODE;
            end else begin
               remaining_in = total - header;
               phase_in     = lpd_pkg::PH_BODY;
            end
         end
         lpd_pkg::PH_BODY: begin
            if (remaining_ff != 16'd0) begin
               remaining_in = remaining_ff - 16'd1;
            end
            if (body_last) begin
               phase_in = lpd_pkg::PH_CODE;
            end
         end
         default: begin
            phase_in = lpd_pkg::PH_CODE;
         end
      endcase
   end

   // Output marks
   always_comb begin
      result                 = '0;
      result.out_byte        = item_byte;
      result.in_packet       = 1'b1;
      result.error_code      = lpd_pkg::ERR_NONE;
      result.long_header     = is_long_ff;
      case (phase_ff)
         lpd_pkg::PH_CODE: begin
            if (is_short_code || is_long_code) begin
               result.start_of_packet = 1'b1;
               result.long_header     = is_long_code;
            end else begin
               result.in_packet   = 1'b0;
               result.long_header = 1'b0;
               result.error_code  = lpd_pkg::ERR_CODE;
            end
         end
         lpd_pkg::PH_LEN, lpd_pkg::PH_LEN_LO: begin
            if (last_len_byte) begin
               if (too_short) begin
                  result.error_code = lpd_pkg::ERR_LENGTH;
               end else if (exact) begin
                  result.end_of_packet = 1'b1;
               end
            end
         end
         lpd_pkg::PH_BODY: begin
            result.end_of_packet = body_last;
         end
         default: begin
            result.in_packet = 1'b0;
         end
      endcase
   end

   // Advance state once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= lpd_pkg::PH_CODE;
         is_long_ff     <= 1'b0;
         length_high_ff <= 8'd0;
         remaining_ff   <= 16'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         is_long_ff     <= is_long_in;
         length_high_ff <= length_high_in;
         remaining_ff   <= remaining_in;
      end
   end

endmodule

// File: rtl/lpd_out_stage.sv
// Result register that holds one marked item until the consumer takes it.
module lpd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lpd_pkg::result_type result,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic [4:0]          rsp_tuser,   // in_packet, start_of_packet, error_code[1:0], long_header
   output logic                rsp_tlast    // end_of_packet
);

   logic                valid_ff;
   logic                valid_in;
   lpd_pkg::result_type data_ff;

   // Free when empty or when the held item is taken this cycle
   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the marked item
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.out_byte;
   assign rsp_tuser  = {data_ff.long_header, data_ff.error_code,
                        data_ff.start_of_packet, data_ff.in_packet};
   assign rsp_tlast  = data_ff.end_of_packet;

endmodule

// File: rtl/length_prefixed_packet_deframer.sv
// Length-prefixed packet deframer: one received byte in, the same byte out
// marked with packet framing. A packet opens with code byte 0xC1/0xC3 (one
// length byte) or 0xC2/0xC4 (two length bytes, high first); the length
// counts the whole packet, header included. Unknown code bytes come out with
// error code 1 and in_packet 0; a length below the header size gives error
// code 2 on the last length byte and framing restarts on the next byte.
// Throughput is one byte per cycle unless rsp_tready stalls the output;
// a byte goes from the input register through the framer into the result
// register. Every accepted byte gives exactly one result.
module length_prefixed_packet_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic [4:0] rsp_tuser,    // in_packet, start_of_packet, error_code[1:0], long_header
   output logic       rsp_tlast     // end_of_packet
);

   logic                item_valid;
   logic [7:0]          item_byte;
   logic                can_load;
   logic                step;
   lpd_pkg::result_type result;

   // Move a byte through the framer when the result register has room
   assign step = item_valid && can_load;

   lpd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (can_load),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   lpd_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item_byte (item_byte),
      .result    (result)
   );

   lpd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/sv/framing_monitor.sv
// Channel monitor for the deframer: predicts the marks of each byte and compares results.
`timescale 1ns / 1ps

module framing_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // in_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // out_byte
   input  logic [4:0] rsp_tuser,    // in_packet, start_of_packet, error_code[1:0], long_header
   input  logic       rsp_tlast,    // end_of_packet
   output int         fault_count,
   output int         pending_results
);

   // Predicted framing state
   lpd_pkg::phase_type frame_phase = lpd_pkg::PH_CODE;
   logic               long_pkt    = 1'b0;
   logic [7:0]         len_high    = 8'h00;
   logic [15:0]        body_left   = 16'h0000;

   lpd_pkg::result_type expected_marks[$];
   int                  faults = 0;

   // Advance the predicted framing state by one byte and return its marks
   function automatic lpd_pkg::result_type mark_byte(input logic [7:0] b);
      lpd_pkg::result_type res;
      logic                have_len;
      logic [15:0]         total;
      logic [15:0]         hdr;
      res.out_byte        = b;
      res.in_packet       = 1'b1;
      res.start_of_packet = 1'b0;
      res.end_of_packet   = 1'b0;
      res.error_code      = lpd_pkg::ERR_NONE;
      have_len            = 1'b0;
      total               = 16'h0000;
      hdr                 = lpd_pkg::HDR_SHORT;
      case (frame_phase)
         lpd_pkg::PH_CODE: begin
            if (b == lpd_pkg::CODE_SHORT_A || b == lpd_pkg::CODE_SHORT_B) begin
               long_pkt            = 1'b0;
               res.start_of_packet = 1'b1;
               frame_phase         = lpd_pkg::PH_LEN;
            end else if (b == lpd_pkg::CODE_LONG_A || b == lpd_pkg::CODE_LONG_B) begin
               long_pkt            = 1'b1;
               res.start_of_packet = 1'b1;
               frame_phase         = lpd_pkg::PH_LEN;
            end else begin
               // mark the unknown code byte as outside a packet, resync on the next one
               res.in_packet  = 1'b0;
               res.error_code = lpd_pkg::ERR_CODE;
            end
         end
         lpd_pkg::PH_LEN: begin
            if (long_pkt) begin
               len_high    = b;
               frame_phase = lpd_pkg::PH_LEN_LO;
            end else begin
               have_len = 1'b1;
               total    = {8'h00, b};
               hdr      = lpd_pkg::HDR_SHORT;
            end
         end
         lpd_pkg::PH_LEN_LO: begin
            have_len = 1'b1;
            total    = {len_high, b};
            hdr      = lpd_pkg::HDR_LONG;
         end
         default: begin
            if (body_left != 16'h0000) body_left = body_left - 16'd1;
            if (body_left == 16'h0000) begin
               res.end_of_packet = 1'b1;
               frame_phase       = lpd_pkg::PH_CODE;
            end
         end
      endcase
      // Close the header: abort, header-only packet, or count down the body
      if (have_len) begin
         if (total < hdr) begin
            res.error_code = lpd_pkg::ERR_LENGTH;
            frame_phase    = lpd_pkg::PH_CODE;
         end else if (total == hdr) begin
            res.end_of_packet = 1'b1;
            frame_phase       = lpd_pkg::PH_CODE;
         end else begin
            body_left   = total - hdr;
            frame_phase = lpd_pkg::PH_BODY;
         end
      end
      res.long_header = res.in_packet ? long_pkt : 1'b0;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         faults++;
      end
   endfunction

   // Compare each accepted result, then queue the prediction for each accepted byte
   always @(posedge clock) begin
      lpd_pkg::result_type want;
      lpd_pkg::result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte        = rsp_tdata;
            got.in_packet       = rsp_tuser[0];
            got.start_of_packet = rsp_tuser[1];
            got.error_code      = lpd_pkg::err_type'(rsp_tuser[3:2]);
            got.long_header     = rsp_tuser[4];
            got.end_of_packet   = rsp_tlast;
            if (expected_marks.size() == 0) begin
               $error("unexpected result: byte 0x%0h", rsp_tdata);
               faults++;
            end else begin
               want = expected_marks.pop_front();
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("in_packet", 8'(want.in_packet), 8'(got.in_packet));
               check_field("start_of_packet", 8'(want.start_of_packet),
                           8'(got.start_of_packet));
               check_field("end_of_packet", 8'(want.end_of_packet),
                           8'(got.end_of_packet));
               check_field("error_code", 8'(want.error_code), 8'(got.error_code));
               check_field("long_header", 8'(want.long_header), 8'(got.long_header));
            end
         end
         if (req_tvalid && req_tready) expected_marks.push_back(mark_byte(req_tdata));
      end
      pending_results <= expected_marks.size();
      fault_count     <= faults;
   end

endmodule

// File: tb/sv/testbench.sv
// Top of the deframer testbench: clock, reset, byte stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int ITEMS_PER_PHASE = 500;
   localparam int HOLD_CYCLES     = 300;
   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 10;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // out_byte
   logic [4:0] rsp_tuser;            // in_packet, start_of_packet, error_code[1:0], long_header
   logic       rsp_tlast;            // end_of_packet

   int   fault_count;
   int   pending_results;
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   int   bytes_sent  = 0;
   logic hold_armed  = 1'b0;
   logic hold_done   = 1'b0;
   int   hold_left   = 0;

   length_prefixed_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   framing_monitor monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fault_count     (fault_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off once armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Offer one item, with random idle cycles ahead of it, and wait until taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_code(input logic want_long);
      logic [7:0] codes_short[2];
      logic [7:0] codes_long[2];
      codes_short = '{lpd_pkg::CODE_SHORT_A, lpd_pkg::CODE_SHORT_B};
      codes_long  = '{lpd_pkg::CODE_LONG_A, lpd_pkg::CODE_LONG_B};
      return want_long ? codes_long[1'($urandom_range(1))]
                       : codes_short[1'($urandom_range(1))];
   endfunction

   // Send a whole packet: code byte, length bytes, then random body bytes
   task automatic send_packet(input logic want_long, input logic [15:0] total);
      int hdr;
      hdr = want_long ? int'(lpd_pkg::HDR_LONG) : int'(lpd_pkg::HDR_SHORT);
      send_byte(pick_code(want_long));
      if (want_long) send_byte(total[15:8]);
      send_byte(total[7:0]);
      for (int i = hdr; i < int'(total); i++) send_byte(8'($urandom_range(255)));
   endtask

   // Mostly well-formed packets, some with a too-short length, some noise
   task automatic send_random_traffic(input int count);
      int          stop_at;
      int          pick;
      logic        want_long;
      logic [15:0] total;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         pick      = $urandom_range(99);
         want_long = 1'($urandom_range(1));
         if (pick < 10) begin
            send_byte(8'($urandom_range(255)));
         end else if (pick < 18) begin
            total = want_long ? 16'($urandom_range(2)) : 16'($urandom_range(1));
            send_packet(want_long, total);
         end else if (want_long) begin
            total = ($urandom_range(99) < 4) ? 16'($urandom_range(300, 256))
                                             : 16'($urandom_range(30, 3));
            send_packet(1'b1, total);
         end else begin
            total = ($urandom_range(99) < 5) ? 16'd255 : 16'($urandom_range(24, 2));
            send_packet(1'b0, total);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: unknown codes, header-only, too-short lengths, short and long bodies
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(lpd_pkg::CODE_SHORT_A); send_byte(8'd2);
      send_byte(lpd_pkg::CODE_SHORT_B); send_byte(8'd3); send_byte(8'hAA);
      send_byte(lpd_pkg::CODE_SHORT_A); send_byte(8'd0);
      send_byte(lpd_pkg::CODE_SHORT_B); send_byte(8'd1);
      send_byte(lpd_pkg::CODE_LONG_A);  send_byte(8'h00); send_byte(8'd3);
      send_byte(lpd_pkg::CODE_LONG_B);  send_byte(8'h00); send_byte(8'd2);
      send_byte(lpd_pkg::CODE_LONG_A);  send_byte(8'h00); send_byte(8'd5);
      send_byte(8'hFF);                 send_byte(8'h00);

      // Random traffic under three idling profiles
      tx_idle_pct <= 26;
      rx_idle_pct <= 45;
      send_random_traffic(ITEMS_PER_PHASE);
      tx_idle_pct <= 45;
      rx_idle_pct <= 26;
      send_random_traffic(ITEMS_PER_PHASE);
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      hold_armed  <= 1'b1;
      send_random_traffic(ITEMS_PER_PHASE);

      // Drain outstanding results, then allow for any stray output
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
